FILE: rtl/dsm_pkg.sv
// Shared types, constants and helper functions for the digit sum multiple counter.
// No dependencies; dsm_update and the top file take names from here by scope.
`default_nettype none

package dsm_pkg;

  localparam int unsigned MAX_DIVISOR = 128;
  localparam int unsigned DIVISOR_W   = 7;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned COUNT_W     = 30;
  localparam int unsigned SUM_W       = 34;   // holds ten counts plus a small tail
  localparam int unsigned CNT_W       = 4;    // tight-branch hits per residue, 0..9
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;
  localparam logic [DIGIT_W-1:0] TOP_DIGIT = 4'd9;
  localparam int unsigned        WIN       = 10;  // digits 0..9 feed each residue

  // register select: paddr[2]
  localparam logic REG_DIVISOR = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_SWEEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;  // begin a sweep over the count store
    logic clr;    // drop all stored counts
  } upd_ctl_t;

  // Reduce a value below 10*COUNT_MOD into 0..COUNT_MOD-1.
  function automatic logic [COUNT_W-1:0] mod_wide(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v;
    for (int k = 1; k < int'(WIN); k++) begin
      if (v >= SUM_W'(k) * SUM_W'(COUNT_MOD)) begin
        r = v - SUM_W'(k) * SUM_W'(COUNT_MOD);
      end
    end
    return r[COUNT_W-1:0];
  endfunction

  // (-9) mod d for d >= 1
  function automatic logic [15:0] neg9_mod(input logic [15:0] d);
    logic [15:0] r;
    if (d > 16'd9) begin
      r = d - 16'd9;
    end else begin
      case (d)
        16'd2:   r = 16'd1;
        16'd4:   r = 16'd3;
        16'd5:   r = 16'd1;
        16'd6:   r = 16'd3;
        16'd7:   r = 16'd5;
        16'd8:   r = 16'd7;
        default: r = 16'd0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dsm_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/dsm_rem.sv
// Iterative restoring remainder unit, one numerator bit per cycle.
// No package dependencies.
`default_nettype none

module dsm_rem #(
  parameter int unsigned NUM_W = 8,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,   // nonzero, held from the cycle after start
  output logic             done,
  output logic [DEN_W-1:0] rem
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    left;
  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] part;
  logic [DEN_W:0]   trial;

  assign trial = {part, sh[NUM_W-1]};
  assign rem   = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CW'(NUM_W);
      end else if (busy) begin
        left <= left - CW'(1);
        if (left == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= num;
      part <= '0;
    end else if (busy) begin
      sh   <= sh << 1;
      part <= (trial >= {1'b0, den}) ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsm_update.sv
// Count store sweep: streams residues through a ten-wide sliding window,
// adds tight-branch hits, reduces and writes back in place. Uses dsm_pkg.
`default_nettype none

module dsm_update #(
  parameter int unsigned MAX_DIVISOR = dsm_pkg::MAX_DIVISOR
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dsm_pkg::upd_ctl_t                     ctl,
  input  logic [$clog2(MAX_DIVISOR+1)-1:0]      dvs,
  input  logic [dsm_pkg::DIGIT_W-1:0]           dig,
  input  logic [$clog2(MAX_DIVISOR)-1:0]        tight,
  output logic [$clog2(MAX_DIVISOR)-1:0]        rd_addr,
  input  logic [dsm_pkg::COUNT_W-1:0]           rd_data,
  output logic                                  wr_en,
  output logic [$clog2(MAX_DIVISOR)-1:0]        wr_addr,
  output logic [dsm_pkg::COUNT_W-1:0]           wr_data,
  output logic                                  done,
  output logic [dsm_pkg::COUNT_W-1:0]           head
);

  localparam int unsigned DW  = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned AW  = $clog2(MAX_DIVISOR);
  localparam int unsigned PW  = $clog2(MAX_DIVISOR + dsm_pkg::WIN);
  localparam int unsigned EW  = DW + 4;
  localparam int unsigned WIN = dsm_pkg::WIN;
  localparam int unsigned CW  = dsm_pkg::COUNT_W;
  localparam int unsigned SW  = dsm_pkg::SUM_W;

  // read side
  logic          rd_busy;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] rd_idx;
  logic          rd_wrap;
  logic          s1_vld;
  logic          s1_out;
  logic          vbit_q;
  logic [DW-1:0] fill;

  // window and residue pipeline
  logic [CW-1:0] line [WIN];
  logic [CW-1:0] val;
  logic [SW-1:0] sum;
  logic          s2_vld;
  logic [AW-1:0] e;
  logic [dsm_pkg::CNT_W-1:0] cnt;
  logic [SW-1:0] tot;
  logic          s3_vld;
  logic [AW-1:0] wr_idx;

  assign rd_addr = rd_idx;
  assign rd_wrap = (DW'(rd_idx) + DW'(1)) == dvs;
  assign val     = vbit_q ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy <= 1'b0;
      rd_pos  <= '0;
      rd_idx  <= '0;
      s1_vld  <= 1'b0;
      s1_out  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      wr_idx  <= '0;
      e       <= '0;
      done    <= 1'b0;
    end else begin
      s1_vld <= rd_busy;
      s1_out <= rd_busy && (rd_pos >= PW'(WIN - 1));
      s2_vld <= s1_vld && s1_out;
      s3_vld <= s2_vld;
      done   <= s3_vld && ((DW'(wr_idx) + DW'(1)) == dvs);
      if (ctl.start) begin
        rd_busy <= 1'b1;
        rd_pos  <= '0;
        rd_idx  <= AW'(dsm_pkg::neg9_mod(16'(dvs)));
        wr_idx  <= '0;
        e       <= (tight == '0) ? AW'(dvs - DW'(1)) : tight - AW'(1);
      end else begin
        if (rd_busy) begin
          rd_pos <= rd_pos + PW'(1);
          rd_idx <= rd_wrap ? '0 : rd_idx + AW'(1);
          if (rd_pos == PW'(dvs) + PW'(WIN - 2)) begin
            rd_busy <= 1'b0;
          end
        end
        if (s2_vld) begin
          e <= (e == '0) ? AW'(dvs - DW'(1)) : e - AW'(1);
        end
        if (s3_vld) begin
          wr_idx <= wr_idx + AW'(1);
        end
      end
    end
  end

  // fill mark: a sweep writes entries 0..d-1, so entries below the mark
  // hold counts since the last clear and the rest read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.clr) begin
      fill <= '0;
    end else if (done && (fill < dvs)) begin
      fill <= dvs;
    end
  end

  always_ff @(posedge clk) begin
    vbit_q <= DW'(rd_idx) < fill;
  end

  // sliding sum over the last ten streamed counts
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < int'(WIN); i++) begin
        line[i] <= '0;
      end
      sum <= '0;
    end else if (s1_vld) begin
      line[0] <= val;
      for (int i = 1; i < int'(WIN); i++) begin
        line[i] <= line[i-1];
      end
      sum <= sum + SW'(val) - SW'(line[WIN-1]);
    end
  end

  // tight-branch hits: digits c' < dig with c' = e (mod dvs)
  always_comb begin
    cnt = '0;
    for (int k = 0; k < int'(dsm_pkg::TOP_DIGIT); k++) begin
      if (EW'(e) + EW'(k) * EW'(dvs) < EW'(dig)) begin
        cnt = cnt + dsm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      tot <= sum + SW'(cnt);
    end
    if (s3_vld && wr_idx == '0) begin
      head <= wr_data;
    end
  end

  assign wr_en   = s3_vld;
  assign wr_addr = wr_idx;
  assign wr_data = dsm_pkg::mod_wide(tot);

endmodule

`default_nettype wire

FILE: rtl/digit_sum_multiple_counter.sv
// Digit sum multiple counter. Takes the decimal digits of a bound K, most
// significant first, one item per digit with last marking the final one, and
// returns one count per bound: how many integers 1..K have a digit sum that is
// a multiple of the divisor register, modulo 1000000007. Divisor 0 acts as 1,
// values above MAX_DIVISOR act as MAX_DIVISOR; digits above 9 act as 9.
// Per-residue counts of prefixes already below K live in a 1R1W RAM of
// MAX_DIVISOR entries; each digit is one in-place sweep over it. A digit item
// runs the serial remainder of the tight residue (NUM_W = clog2(MAX_DIVISOR+9)
// numerator bits), then d+9 RAM reads (d = effective divisor) through a
// ten-wide sliding window plus pipeline drain, before the next digit is
// accepted; the last digit of a bound also passes a finish state. The RAM
// needs no clearing pass; a fill mark (entries written since the last clear)
// makes the rest read as zero and is dropped after reset and after each bound.
// A result waits in an output register while the next bound's digits are
// already being accepted; that bound's last digit stalls until the earlier
// result is taken. Uses dsm_pkg, dsm_ram, dsm_rem, dsm_update.
`default_nettype none

module digit_sum_multiple_counter #(
  parameter int unsigned MAX_DIVISOR = dsm_pkg::MAX_DIVISOR
) (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsm_pkg::APB_AW-1:0]        paddr,
  input  logic [dsm_pkg::APB_DW-1:0]        pwdata,
  output logic [dsm_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // digit items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dsm_pkg::DIGIT_W-1:0]       digit,
  input  logic                              last,
  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dsm_pkg::COUNT_W-1:0]       count
);

  localparam int unsigned DW = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned AW = $clog2(MAX_DIVISOR);
  localparam int unsigned NW = $clog2(MAX_DIVISOR + 9);
  localparam int unsigned CW = dsm_pkg::COUNT_W;

  dsm_pkg::state_t   state;
  dsm_pkg::state_t   state_next;
  dsm_pkg::upd_ctl_t ctl;

  logic [dsm_pkg::DIVISOR_W-1:0] divisor;
  logic [DW-1:0]                 deff;
  logic [DW-1:0]                 dvs_q;
  logic [dsm_pkg::DIGIT_W-1:0]   dig_sat;
  logic [dsm_pkg::DIGIT_W-1:0]   dig_q;
  logic                          last_q;
  logic [AW-1:0]                 tight;
  logic                          accept;
  logic                          cfg_wr;
  logic                          load_out;

  logic          rem_done;
  logic [DW-1:0] rem;
  logic          upd_done;
  logic [CW-1:0] head;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic [CW:0]   fin;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == dsm_pkg::REG_DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= dsm_pkg::DIVISOR_W'(1);
    end else if (cfg_wr) begin
      divisor <= pwdata[dsm_pkg::DIVISOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == dsm_pkg::REG_DIVISOR)
                  ? dsm_pkg::APB_DW'(divisor) : '0;

  // effective divisor: zero acts as one, clamp at the store depth
  always_comb begin
    if (divisor == '0) begin
      deff = DW'(1);
    end else if (16'(divisor) > 16'(MAX_DIVISOR)) begin
      deff = DW'(MAX_DIVISOR);
    end else begin
      deff = DW'(divisor);
    end
  end

  assign dig_sat = (digit > dsm_pkg::TOP_DIGIT) ? dsm_pkg::TOP_DIGIT : digit;

  // ---------------- control ----------------
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      dsm_pkg::S_IDLE: begin
        if (accept) state_next = dsm_pkg::S_REM;
      end
      dsm_pkg::S_REM: begin
        if (rem_done) state_next = dsm_pkg::S_SWEEP;
      end
      dsm_pkg::S_SWEEP: begin
        if (upd_done) state_next = last_q ? dsm_pkg::S_FINISH : dsm_pkg::S_IDLE;
      end
      dsm_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = dsm_pkg::S_IDLE;
      end
      default: state_next = dsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctl.start = 1'b0;
    ctl.clr   = 1'b0;
    load_out  = 1'b0;
    case (state)
      dsm_pkg::S_IDLE:   in_ready  = 1'b1;
      dsm_pkg::S_REM:    ctl.start = rem_done;
      dsm_pkg::S_SWEEP:  ;
      dsm_pkg::S_FINISH: begin
        load_out = !out_valid || out_ready;
        ctl.clr  = load_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsm_pkg::S_IDLE;
      tight     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        tight <= rem[AW-1:0];
      end else if (ctl.clr) begin
        tight <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dig_q  <= dig_sat;
      last_q <= last;
      dvs_q  <= deff;
    end
    if (load_out) begin
      count <= (fin == '0) ? dsm_pkg::COUNT_MOD - CW'(1) : CW'(fin - (CW+1)'(1));
    end
  end

  // store entry 0 plus the tight path when its residue is zero, minus the number zero
  assign fin = (CW+1)'(head) + ((tight == '0) ? (CW+1)'(1) : '0);

  // ---------------- datapath ----------------
  // new tight residue (tight + digit) mod d, one bit per cycle
  dsm_rem #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .num   (NW'(tight) + NW'(dig_sat)),
    .den   (dvs_q),
    .done  (rem_done),
    .rem   (rem)
  );

  dsm_update #(
    .MAX_DIVISOR (MAX_DIVISOR)
  ) u_update (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .dvs     (dvs_q),
    .dig     (dig_q),
    .tight   (rem[AW-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .done    (upd_done),
    .head    (head)
  );

  dsm_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_DIVISOR)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- checks ----------------
  a_rem_in_rem: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == dsm_pkg::S_REM)
    else $error("remainder finished outside its phase");

  a_upd_in_sweep: assert property (@(posedge clk) disable iff (rst)
    upd_done |-> state == dsm_pkg::S_SWEEP)
    else $error("sweep finished outside its phase");

  a_tight_reduced: assert property (@(posedge clk) disable iff (rst)
    state == dsm_pkg::S_SWEEP |-> DW'(tight) < dvs_q)
    else $error("tight residue not below divisor");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count < dsm_pkg::COUNT_MOD)
    else $error("count not reduced");

endmodule

`default_nettype wire
